FILE: rtl/tmbw_pkg.sv
// shared constants, codes and entry packing for the text tile map box writer
package tmbw_pkg;

    // map geometry
    localparam int COLUMNS     = 32;
    localparam int ROWS        = 28;
    localparam int STRIDE_BITS = 5;
    localparam int STRIDE      = 1 << STRIDE_BITS;
    localparam int MAP_DEPTH   = ROWS * STRIDE;
    localparam int MAP_AW      = $clog2(MAP_DEPTH);

    // entry layout
    localparam int ENTRY_W = 14;
    localparam int PAL_LSB = 10;
    localparam logic [ENTRY_W-1:0] PRIORITY_BIT = 14'h2000;
    localparam logic [2:0] PAL_BASE = 3'd4;

    // command kinds
    localparam logic [2:0] KIND_CLEAR  = 3'd0;
    localparam logic [2:0] KIND_PUT    = 3'd1;
    localparam logic [2:0] KIND_BOX    = 3'd2;
    localparam logic [2:0] KIND_READ   = 3'd3;
    localparam logic [2:0] KIND_VBLANK = 3'd4;

    // box glyphs
    localparam logic [7:0] GL_TOP_LEFT     = 8'd1;
    localparam logic [7:0] GL_TOP          = 8'd2;
    localparam logic [7:0] GL_TOP_RIGHT    = 8'd3;
    localparam logic [7:0] GL_LEFT         = 8'd4;
    localparam logic [7:0] GL_RIGHT        = 8'd5;
    localparam logic [7:0] GL_BOTTOM_LEFT  = 8'd6;
    localparam logic [7:0] GL_BOTTOM       = 8'd7;
    localparam logic [7:0] GL_BOTTOM_RIGHT = 8'd8;
    localparam logic [7:0] GL_SPACE        = 8'h20;

    function automatic logic [ENTRY_W-1:0] pack_entry(input logic [7:0] glyph,
                                                      input logic [1:0] pal);
        logic [2:0] pal_field;
        pal_field = PAL_BASE + {1'b0, pal};
        return PRIORITY_BIT | (ENTRY_W'(pal_field) << PAL_LSB) | ENTRY_W'(glyph);
    endfunction

    function automatic logic cell_ok(input logic [7:0] x, input logic [7:0] y);
        return (x < 8'(COLUMNS)) && (y < 8'(ROWS));
    endfunction

    function automatic logic [MAP_AW-1:0] cell_addr(input logic [7:0] x,
                                                    input logic [7:0] y);
        return MAP_AW'({y[STRIDE_BITS-1:0], x[STRIDE_BITS-1:0]});
    endfunction

endpackage

FILE: rtl/tmbw_ram.sv
// generic simple dual port ram with registered read
module tmbw_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 896
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/text_tile_map_box_writer.sv
// text tile map box writer: command decode, box walker and map memory control
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  command | i_in_valid / o_in_ready, i_kind .. i_vblank_active | in
//  result  | o_out_valid / i_out_ready, o_read_entry,   | out
//          | o_copy_grant, o_map_dirty                  |
//
// put glyph and an in-range read pass through S_PUT or S_READ, then S_RESULT; a vblank
// check, a clipped read, an unused kind or a box under 2 cells on a side go straight to
// S_RESULT; the box walker writes its width*height cells one per cycle through the
// single write port of the map ram; clear walks every map address for the same reason
// after reset a pass over all MAP_DEPTH (896) cells zeroes the map; no command taken
// one command at a time; the next can be taken in the same cycle the result goes valid,
// while that result still waits; a stalled result holds the block in its result state
module text_tile_map_box_writer
    import tmbw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_kind,
    input  logic [7:0]          i_pos_x,
    input  logic [7:0]          i_pos_y,
    input  logic [7:0]          i_box_width,
    input  logic [7:0]          i_box_height,
    input  logic [7:0]          i_glyph_code,
    input  logic [1:0]          i_palette_sel,
    input  logic                i_vblank_active,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [ENTRY_W-1:0]  o_read_entry,
    output logic                o_copy_grant,
    output logic                o_map_dirty
);
    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_CLEAR  = 7'b0000100,
        S_PUT    = 7'b0001000,
        S_BOX    = 7'b0010000,
        S_READ   = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    localparam logic [MAP_AW-1:0] LAST_ADDR = MAP_AW'(MAP_DEPTH - 1);

    t_state              r_state, n_state;
    logic [MAP_AW-1:0]   r_cnt, n_cnt;
    logic [7:0]          r_ci, n_ci;
    logic [7:0]          r_cj, n_cj;
    logic                r_dirty, n_dirty;
    logic [ENTRY_W-1:0]  r_res_entry, n_res_entry;
    logic                r_res_grant, n_res_grant;
    logic                r_out_valid, n_out_valid;
    logic [ENTRY_W-1:0]  r_out_entry, n_out_entry;
    logic                r_out_grant, n_out_grant;
    logic                r_out_dirty, n_out_dirty;

    // latched command payload
    logic [7:0]          r_px, r_py, r_bw, r_bh, r_gl;
    logic [1:0]          r_pal;

    // map ram ports
    logic                ram_we;
    logic [MAP_AW-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [MAP_AW-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic                in_acc;
    logic                out_free;
    logic [7:0]          box_x, box_y;
    logic                last_col, last_row;
    logic [7:0]          box_glyph;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // box walker cell position, wraps modulo 256 before clipping
    assign box_x    = r_px + r_ci;
    assign box_y    = r_py + r_cj;
    assign last_col = (r_ci == r_bw - 8'd1);
    assign last_row = (r_cj == r_bh - 8'd1);

    // border glyph by position within the box
    always_comb begin
        if (r_cj == 8'd0) begin
            box_glyph = (r_ci == 8'd0) ? GL_TOP_LEFT : (last_col ? GL_TOP_RIGHT : GL_TOP);
        end else if (last_row) begin
            box_glyph = (r_ci == 8'd0) ? GL_BOTTOM_LEFT
                                       : (last_col ? GL_BOTTOM_RIGHT : GL_BOTTOM);
        end else begin
            box_glyph = (r_ci == 8'd0) ? GL_LEFT : (last_col ? GL_RIGHT : GL_SPACE);
        end
    end

    // read address comes straight from the command so data is ready in S_READ
    assign ram_raddr = cell_addr(i_pos_x, i_pos_y);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ci        = r_ci;
        n_cj        = r_cj;
        n_dirty     = r_dirty;
        n_res_entry = r_res_entry;
        n_res_grant = r_res_grant;
        n_out_valid = r_out_valid;
        n_out_entry = r_out_entry;
        n_out_grant = r_out_grant;
        n_out_dirty = r_out_dirty;
        ram_we      = 1'b0;
        ram_waddr   = r_cnt;
        ram_wdata   = '0;
        ram_re      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                // power-on clearing pass
                ram_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_ADDR) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_res_entry = '0;
                    n_res_grant = 1'b0;
                    unique case (i_kind)
                        KIND_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_CLEAR;
                        end
                        KIND_PUT: begin
                            n_state = S_PUT;
                        end
                        KIND_BOX: begin
                            n_ci = '0;
                            n_cj = '0;
                            if (i_box_width < 8'd2 || i_box_height < 8'd2) begin
                                n_state = S_RESULT;
                            end else begin
                                n_state = S_BOX;
                            end
                        end
                        KIND_READ: begin
                            // clipped reads answer zero without touching the ram
                            if (cell_ok(i_pos_x, i_pos_y)) begin
                                ram_re  = 1'b1;
                                n_state = S_READ;
                            end else begin
                                n_state = S_RESULT;
                            end
                        end
                        KIND_VBLANK: begin
                            if (r_dirty && i_vblank_active) begin
                                n_res_grant = 1'b1;
                                n_dirty     = 1'b0;
                            end
                            n_state = S_RESULT;
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_ADDR) begin
                    n_cnt   = '0;
                    n_dirty = 1'b1;
                    n_state = S_RESULT;
                end
            end
            S_PUT: begin
                ram_waddr = cell_addr(r_px, r_py);
                ram_wdata = pack_entry(r_gl, r_pal);
                if (cell_ok(r_px, r_py)) begin
                    ram_we  = 1'b1;
                    n_dirty = 1'b1;
                end
                n_state = S_RESULT;
            end
            S_BOX: begin
                // one cell per cycle, row by row; all cells of a box are distinct
                ram_waddr = cell_addr(box_x, box_y);
                ram_wdata = pack_entry(box_glyph, r_pal);
                if (cell_ok(box_x, box_y)) begin
                    ram_we  = 1'b1;
                    n_dirty = 1'b1;
                end
                if (last_col) begin
                    n_ci = '0;
                    if (last_row) begin
                        n_state = S_RESULT;
                    end else begin
                        n_cj = r_cj + 8'd1;
                    end
                end else begin
                    n_ci = r_ci + 8'd1;
                end
            end
            S_READ: begin
                n_res_entry = ram_rdata;
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_entry = r_res_entry;
                    n_out_grant = r_res_grant;
                    n_out_dirty = r_dirty;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_dirty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_dirty     <= n_dirty;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and walker registers
    always_ff @(posedge i_clk) begin
        r_ci        <= n_ci;
        r_cj        <= n_cj;
        r_res_entry <= n_res_entry;
        r_res_grant <= n_res_grant;
        r_out_entry <= n_out_entry;
        r_out_grant <= n_out_grant;
        r_out_dirty <= n_out_dirty;
        if (in_acc) begin
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_bw  <= i_box_width;
            r_bh  <= i_box_height;
            r_gl  <= i_glyph_code;
            r_pal <= i_palette_sel;
        end
    end

    tmbw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_read_entry = r_out_entry;
    assign o_copy_grant = r_out_grant;
    assign o_map_dirty  = r_out_dirty;
endmodule
